/* design/fqop_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fqop_pkg
// Shared data width, operation codes and status codes of the odd-purge queue.
// ----------------------------------------------------------------------------
package fqop_pkg;

    localparam int DATA_W = 32;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_PURGE = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [DATA_W-1:0] data_t;

endpackage
`default_nettype wire

/* design/fqop_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fqop_ram
// Ring store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fqop_ram
    import fqop_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire data_t                    wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output data_t                         rd_data
);

    data_t mem [DEPTH];
    data_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* design/fifo_queue_with_odd_purge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_queue_with_odd_purge
// Bounded FIFO of signed 32-bit values with push, pop and purge-odd requests.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives one result. A push, a
// rejected request or an unused mode is answered directly; a pop makes one
// read of the ring memory and answers from a wait state; a purge walks the
// held entries through the single read port of the ring memory, writing
// kept even values back in order from the head. A new request is taken once
// the previous one is finished and the result register is free or being
// emptied in that cycle.
// ----------------------------------------------------------------------------
module fifo_queue_with_odd_purge
    import fqop_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     mode,
    input  wire logic signed [DATA_W-1:0]       value,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [DATA_W-1:0]            popped,
    output logic [1:0]                          status,
    output logic [$clog2(DEPTH+1)-1:0]          fill
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POPW  = 2'd1;
    localparam logic [1:0] S_PURGE = 2'd2;

    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic          rd_pend_reg, rd_pend_next;

    logic          out_valid_reg, out_valid_next;
    data_t         popped_reg, popped_next;
    logic [1:0]    status_reg, status_next;
    logic [CW-1:0] fill_reg, fill_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    data_t         wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    data_t         rd_data;

    logic          out_free;
    logic          in_accept;
    logic          issue;
    logic          keep;
    logic [CW-1:0] kept_final;

    fqop_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == S_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;

    assign issue      = (k_reg < occ_reg);
    assign keep       = rd_pend_reg && !rd_data[0];
    assign kept_final = kept_reg + CW'(keep);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        occ_next       = occ_reg;
        k_next         = k_reg;
        kept_next      = kept_reg;
        rd_pend_next   = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        popped_next    = popped_reg;
        status_next    = status_reg;
        fill_next      = fill_reg;
        wr_en          = 1'b0;
        wr_addr        = ring_pos(head_reg, occ_reg);
        wr_data        = value;
        rd_en          = 1'b0;
        rd_addr        = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    popped_next = '0;
                    status_next = ST_DONE;
                    fill_next   = occ_reg;
                    unique case (mode)
                        MODE_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            if (occ_reg == CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                occ_next  = occ_reg + CW'(1);
                                fill_next = occ_reg + CW'(1);
                            end
                        end
                        MODE_POP:
                        begin
                            if (occ_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_POPW;
                            end
                        end
                        MODE_PURGE:
                        begin
                            if (occ_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en        = 1'b1;
                                rd_pend_next = 1'b1;
                                k_next       = CW'(1);
                                kept_next    = '0;
                                state_next   = S_PURGE;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_POPW:
            begin
                out_valid_next = 1'b1;
                popped_next    = rd_data;
                status_next    = ST_DONE;
                occ_next       = occ_reg - CW'(1);
                fill_next      = occ_reg - CW'(1);
                head_next      = (occ_reg == CW'(1)) ? '0 : ring_pos(head_reg, CW'(1));
                state_next     = S_IDLE;
            end
            S_PURGE:
            begin
                rd_addr = ring_pos(head_reg, k_reg);
                wr_addr = ring_pos(head_reg, kept_reg);
                wr_data = rd_data;
                wr_en   = keep;
                if (issue)
                begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    k_next       = k_reg + CW'(1);
                end
                kept_next = kept_final;
                if (!issue && rd_pend_reg)
                begin
                    out_valid_next = 1'b1;
                    popped_next    = '0;
                    status_next    = ST_DONE;
                    fill_next      = kept_final;
                    occ_next       = kept_final;
                    if (kept_final == '0)
                    begin
                        head_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            k_reg         <= '0;
            kept_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            k_reg         <= k_next;
            kept_reg      <= kept_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        status_reg <= status_next;
        fill_reg   <= fill_next;
    end

    assign out_valid = out_valid_reg;
    assign popped    = popped_reg;
    assign status    = status_reg;
    assign fill      = fill_reg;

endmodule
`default_nettype wire

/* tb/fifo_queue_with_odd_purge_tb.sv */
// ----------------------------------------------------------------------------
// fifo_queue_with_odd_purge_tb
// Self-checking bench for the odd-purge FIFO queue.
// ----------------------------------------------------------------------------
// Push, pop, purge and unused-mode requests go in through the valid/stall
// port, with random gaps on the request side and random stalls on the result
// side. A scoreboard keeps its own copy of the ring and its occupancy and
// predicts popped value, status and fill for every accepted request. Each
// result is compared in order. A short directed run hits the empty and
// purge corner cases first. Random runs follow, biased toward filling,
// draining or mixed traffic.
// ----------------------------------------------------------------------------
module fifo_queue_with_odd_purge_tb
    import fqop_pkg::*;
();

    localparam int QDEPTH = 16;
    localparam int FILL_W = $clog2(QDEPTH + 1);
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        data_t             popped;
        logic [1:0]        status;
        logic [FILL_W-1:0] fill;
    } queue_result_t;

    class odd_purge_scoreboard;
        data_t         ring [QDEPTH];
        int unsigned   head;
        int unsigned   held;
        queue_result_t awaited[$];
        int            errors;
        int            requests;
        int            results;
        int            purges;
        int            full_rejects;
        int            empty_rejects;

        function new();
            head = 0;
            held = 0;
            errors = 0;
            requests = 0;
            results = 0;
            purges = 0;
            full_rejects = 0;
            empty_rejects = 0;
        endfunction

        function void note_request(logic [1:0] op, data_t v);
            queue_result_t r;
            int unsigned   kept;
            data_t         w;
            r.popped = '0;
            r.status = ST_DONE;
            requests++;
            case (op)
                MODE_PUSH:
                begin
                    if (held == QDEPTH)
                    begin
                        r.status = ST_FULL;
                        full_rejects++;
                    end
                    else
                    begin
                        ring[(head + held) % QDEPTH] = v;
                        held++;
                    end
                end
                MODE_POP:
                begin
                    if (held == 0)
                    begin
                        r.status = ST_EMPTY;
                        empty_rejects++;
                    end
                    else
                    begin
                        r.popped = ring[head];
                        head = (head + 1) % QDEPTH;
                        held--;
                        if (held == 0)
                            head = 0;
                    end
                end
                MODE_PURGE:
                begin
                    purges++;
                    if (held == 0)
                    begin
                        r.status = ST_EMPTY;
                        empty_rejects++;
                    end
                    else
                    begin
                        kept = 0;
                        for (int k = 0; k < held; k++)
                        begin
                            w = ring[(head + k) % QDEPTH];
                            if (!w[0])
                            begin
                                ring[(head + kept) % QDEPTH] = w;
                                kept++;
                            end
                        end
                        held = kept;
                        if (held == 0)
                            head = 0;
                    end
                end
                default:
                begin
                end
            endcase
            r.fill = held[FILL_W-1:0];
            awaited.push_back(r);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 30)
                $display("MISMATCH result %0d: %s", results, what);
        endtask

        task check_result(data_t p, logic [1:0] s, logic [FILL_W-1:0] f);
            queue_result_t want;
            results++;
            if (awaited.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
                return;
            end
            want = awaited.pop_front();
            if (p !== want.popped)
                report_mismatch($sformatf("popped %0h, expected %0h", p, want.popped));
            if (s !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", s, want.status));
            if (f !== want.fill)
                report_mismatch($sformatf("fill %0d, expected %0d", f, want.fill));
        endtask
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [1:0]               mode = MODE_PUSH;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] popped;
    logic [1:0]               status;
    logic [FILL_W-1:0]        fill;

    bit                       steady = 1'b0;
    odd_purge_scoreboard      board = new();

    fifo_queue_with_odd_purge #(.DEPTH(QDEPTH)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .popped    (popped),
        .status    (status),
        .fill      (fill)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #3000000;
        $display("fifo_queue_with_odd_purge_tb: FAIL");
        $finish;
    end

    // result side: random stalls, checked at the rising edge
    initial
    begin
        forever
        begin
            @(negedge clk);
            out_stall = !steady && ($urandom_range(99) < 32);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_result(popped, status, fill);
        end
    end

    task automatic idle_gap();
        while (!steady && $urandom_range(99) < 32)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            mode = 2'($urandom_range(3));
            value = $urandom;
        end
    endtask

    task automatic send_request(logic [1:0] op, data_t v);
        idle_gap();
        @(negedge clk);
        in_valid = 1'b1;
        mode = op;
        value = v;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(op, v);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
    endtask

    function automatic data_t pick_value(int even_pct);
        data_t v;
        v = $urandom;
        case ($urandom_range(19))
            0: v = 32'h7fff_ffff;
            1: v = 32'h8000_0000;
            2: v = '0;
            3: v = '1;
            default: v = v;
        endcase
        v[0] = ($urandom_range(99) >= even_pct);
        return v;
    endfunction

    function automatic logic [1:0] pick_op(int push_pct, int pop_pct, int purge_pct);
        int r;
        r = $urandom_range(99);
        if (r < push_pct)
            return MODE_PUSH;
        else if (r < push_pct + pop_pct)
            return MODE_POP;
        else if (r < push_pct + pop_pct + purge_pct)
            return MODE_PURGE;
        return MODE_UNUSED;
    endfunction

    initial
    begin
        int sent;
        int run_len;
        int kind;
        int guard;
        bit paused;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty rejects, extremes, purge keeping some, all and none
        send_request(MODE_POP, '0);
        send_request(MODE_PURGE, '0);
        send_request(MODE_UNUSED, 32'hdead_beef);
        send_request(MODE_PUSH, 32'h7fff_ffff);
        send_request(MODE_PUSH, 32'h8000_0000);
        send_request(MODE_PUSH, 32'hffff_ffff);
        send_request(MODE_PUSH, 32'h0000_0000);
        send_request(MODE_PUSH, 32'h0000_0002);
        send_request(MODE_UNUSED, 32'h0000_0001);
        send_request(MODE_PURGE, '1);
        send_request(MODE_POP, '0);
        send_request(MODE_POP, '0);
        send_request(MODE_PUSH, 32'h0000_0001);
        send_request(MODE_PUSH, 32'hffff_fffd);
        send_request(MODE_POP, '0);
        send_request(MODE_PURGE, '0);
        send_request(MODE_PUSH, 32'hffff_fffe);
        send_request(MODE_PUSH, 32'h0000_0004);
        send_request(MODE_PURGE, '0);
        send_request(MODE_POP, '0);
        send_request(MODE_POP, '0);
        send_request(MODE_POP, '0);
        wait_drained();

        // random runs biased toward filling, draining or mixed traffic
        sent = 0;
        paused = 1'b0;
        kind = 0;
        while (sent < 550)
        begin
            run_len = (sent == 0) ? 28 : $urandom_range(8, 40);
            for (int i = 0; i < run_len && sent < 550; i++)
            begin
                steady = (sent >= 200 && sent < 320);
                if (!paused && sent >= 260)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                case (kind)
                    0: send_request(pick_op(78, 8, 10), pick_value(75));
                    1: send_request(pick_op(20, 65, 10), pick_value(50));
                    default: send_request(pick_op(45, 35, 14), pick_value(60));
                endcase
                sent++;
            end
            kind = $urandom_range(2);
        end
        steady = 1'b0;

        @(negedge clk);
        in_valid = 1'b0;
        guard = 0;
        while (board.awaited.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (30) @(posedge clk);
        if (board.awaited.size() != 0)
            board.report_mismatch($sformatf("%0d results never arrived",
                                            board.awaited.size()));

        $display("Covered %0d requests incl. %0d purges; %0d full and %0d empty rejects.",
                 board.requests, board.purges, board.full_rejects, board.empty_rejects);
        $display("Checked %0d results, %0d mismatches.", board.results, board.errors);
        if (board.errors == 0)
            $display("fifo_queue_with_odd_purge_tb: PASS");
        else
            $display("fifo_queue_with_odd_purge_tb: FAIL");
        $finish;
    end

endmodule
